// ===== hw/rtl/pcbm_pkg.sv =====
// shared types, field widths and the tile size table of the paged circular buffer manager
`timescale 1ns / 1ps
`default_nettype none

package pcbm_pkg;

    // input field widths
    localparam int CMD_W     = 4;
    localparam int IDX_IN_W  = 5;
    localparam int PAGE_W    = 16;
    localparam int ADDR_IN_W = 17;
    localparam int TOTAL_W   = 16;
    localparam int BPTR_W    = 21;
    localparam int FMT_W     = 3;

    // output field widths
    localparam int TILE_IDX_W = 16;
    localparam int TSZ_W      = 9;
    localparam int TBYTES_W   = 13;
    localparam int CNT_W      = 32;

    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 80;

    localparam logic [TSZ_W-1:0] TILE_WORDS_RESET = TSZ_W'(4096 >> 4);

    typedef enum logic [CMD_W-1:0] {
        CMD_SETUP      = 4'd0,
        CMD_SET_FORMAT = 4'd1,
        CMD_PUSH       = 4'd2,
        CMD_POP        = 4'd3,
        CMD_RESERVE_Q  = 4'd4,
        CMD_WAIT_Q     = 4'd5,
        CMD_SET_WR_PTR = 4'd6,
        CMD_SET_RD_PTR = 4'd7,
        CMD_INCR_TILE  = 4'd8
    } t_cmd;

    typedef enum logic [FMT_W-1:0] {
        FMT_HALF    = 3'd0,
        FMT_BFP8    = 3'd1,
        FMT_FLOAT32 = 3'd2,
        FMT_BFP4    = 3'd3,
        FMT_BFP2    = 3'd4
    } t_fmt;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture an accepted beat and start the entry read
        logic step;    // entry read is back: latch it and form the pointer step
        logic commit;  // write back the entry and load the result register
    } t_dp_ctl;

    // tile size in 16-byte words; unknown codes take the bfp8 size
    function automatic logic [TSZ_W-1:0] tile_words(input logic [FMT_W-1:0] fmt);
        logic [TSZ_W-1:0] words;
        unique case (fmt)
            FMT_HALF:    words = TSZ_W'(2048 >> 4);
            FMT_FLOAT32: words = TSZ_W'(4096 >> 4);
            FMT_BFP4:    words = TSZ_W'((512 >> 4) + (64 >> 4));
            FMT_BFP2:    words = TSZ_W'((256 >> 4) + (64 >> 4));
            default:     words = TSZ_W'((1024 >> 4) + (64 >> 4));
        endcase
        return words;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcbm_ram.sv =====
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pcbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/pcbm_ctrl.sv =====
// controller: beat handshakes and the read, step, write-back sequence
`timescale 1ns / 1ps
`default_nettype none

module pcbm_ctrl
    import pcbm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    output logic      o_s_ready,
    output logic      o_m_valid,
    input  wire logic i_m_ready,
    output t_dp_ctl   o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_commit;

    assign w_accept = i_s_valid && r_ready;
    // the result register is free if empty or being drained this cycle
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || i_m_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                        r_ready <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready     = r_ready;
    assign o_m_valid     = r_out_valid;
    assign o_ctl.load    = w_accept;
    assign o_ctl.step    = (r_state == S_MUL);
    assign o_ctl.commit  = w_commit;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_state == S_IDLE)
        else $error("input ready while a command is in flight");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_MUL && !r_ready)
        else $error("accepted beat did not start the sequence");

    a_mul_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |=> r_state == S_UPD)
        else $error("step stage not followed by write-back");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid && r_ready)
        else $error("write-back did not present a result");

endmodule

`default_nettype wire

// ===== hw/rtl/pcbm_dp.sv =====
// datapath: per-buffer state ram, pointer step arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none

module pcbm_dp
    import pcbm_pkg::*;
#(
    parameter int BUFFER_COUNT   = 32,
    parameter int WORD_ADDR_BITS = 17
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_ctl                i_ctl,
    input  wire logic [CMD_W-1:0]       i_command,
    input  wire logic [IDX_IN_W-1:0]    i_buffer_index,
    input  wire logic [PAGE_W-1:0]      i_page_count,
    input  wire logic [ADDR_IN_W-1:0]   i_base_word_addr,
    input  wire logic [ADDR_IN_W-1:0]   i_size_words,
    input  wire logic [TOTAL_W-1:0]     i_total_pages,
    input  wire logic [ADDR_IN_W-1:0]   i_page_words,
    input  wire logic [BPTR_W-1:0]      i_byte_pointer,
    input  wire logic [FMT_W-1:0]       i_format_code,
    output logic      [BPTR_W-1:0]      o_write_byte_ptr,
    output logic      [BPTR_W-1:0]      o_read_byte_ptr,
    output logic      [TILE_IDX_W-1:0]  o_tile_write_index,
    output logic      [TBYTES_W-1:0]    o_tile_bytes,
    output logic                        o_space_ok,
    output logic                        o_data_ok
);

    localparam int W       = WORD_ADDR_BITS;
    localparam int LW      = W + 1;
    // a set-pointer command stores 17 bits even when the pointer is narrower
    localparam int PB      = (LW > 17) ? LW : 17;
    localparam int PRD_W   = PAGE_W + W;
    localparam int SUM_W   = ((PRD_W > PB) ? PRD_W : PB) + 1;
    localparam int AW      = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
    localparam int ENTRY_W = 2 * PB + 2 * CNT_W + TILE_IDX_W + TSZ_W + LW + 2 * W + TOTAL_W;

    // captured beat
    t_cmd                  r_cmd;
    logic                  r_idx_ok;
    logic [AW-1:0]         r_addr;
    logic [PAGE_W-1:0]     r_pages;
    logic [ADDR_IN_W-1:0]  r_base;
    logic [ADDR_IN_W-1:0]  r_size;
    logic [TOTAL_W-1:0]    r_total;
    logic [ADDR_IN_W-1:0]  r_psz_in;
    logic [BPTR_W-1:0]     r_bptr;
    logic [FMT_W-1:0]      r_fmt;

    logic [BUFFER_COUNT-1:0] r_valid;

    // latched entry
    logic [PB-1:0]         r_wr;
    logic [PB-1:0]         r_rd;
    logic [CNT_W-1:0]      r_push;
    logic [CNT_W-1:0]      r_pop;
    logic [TILE_IDX_W-1:0] r_tile;
    logic [TSZ_W-1:0]      r_tsz;
    logic [LW-1:0]         r_lim;
    logic [W-1:0]          r_len;
    logic [W-1:0]          r_psz;
    logic [TOTAL_W-1:0]    r_cap;
    logic [PRD_W-1:0]      r_prod;

    // ram read view
    logic [ENTRY_W-1:0]    w_ram_rdata;
    logic [ENTRY_W-1:0]    w_ram_wdata;
    logic [PB-1:0]         w_e_wr;
    logic [PB-1:0]         w_e_rd;
    logic [CNT_W-1:0]      w_e_push;
    logic [CNT_W-1:0]      w_e_pop;
    logic [TILE_IDX_W-1:0] w_e_tile;
    logic [TSZ_W-1:0]      w_e_tsz;
    logic [LW-1:0]         w_e_lim;
    logic [W-1:0]          w_e_len;
    logic [W-1:0]          w_e_psz;
    logic [TOTAL_W-1:0]    w_e_cap;
    logic                  w_hit;
    logic [W-1:0]          w_sel_psz;

    // next entry
    logic [PB-1:0]         n_wr;
    logic [PB-1:0]         n_rd;
    logic [CNT_W-1:0]      n_push;
    logic [CNT_W-1:0]      n_pop;
    logic [TILE_IDX_W-1:0] n_tile;
    logic [TSZ_W-1:0]      n_tsz;
    logic [LW-1:0]         n_lim;
    logic [W-1:0]          n_len;
    logic [W-1:0]          n_psz;
    logic [TOTAL_W-1:0]    n_cap;

    logic [PB-1:0]         w_adv_from;
    logic [SUM_W-1:0]      w_sum;
    logic [SUM_W-1:0]      w_wrapped;
    logic [PB-1:0]         w_adv;
    logic [W-1:0]          w_base_w;
    logic [W-1:0]          w_len_w;
    logic [CNT_W-1:0]      w_used;
    logic [CNT_W-1:0]      w_free;
    logic                  w_wen;

    logic [BPTR_W-1:0]     r_out_wr;
    logic [BPTR_W-1:0]     r_out_rd;
    logic [TILE_IDX_W-1:0] r_out_tile;
    logic [TBYTES_W-1:0]   r_out_tbytes;
    logic                  r_out_space;
    logic                  r_out_data;

    function automatic logic [BPTR_W-5:0] w_out_wptr(input logic [PB-1:0] ptr);
        return ptr[BPTR_W-5:0];
    endfunction

    assign w_wen = i_ctl.commit && r_idx_ok;

    pcbm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUFFER_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_wen),
        .i_waddr (r_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_ctl.load),
        .i_raddr (AW'(i_buffer_index)),
        .o_rdata (w_ram_rdata)
    );

    assign {w_e_wr, w_e_rd, w_e_push, w_e_pop, w_e_tile, w_e_tsz,
            w_e_lim, w_e_len, w_e_psz, w_e_cap} = w_ram_rdata;
    assign w_ram_wdata = {n_wr, n_rd, n_push, n_pop, n_tile, n_tsz,
                          n_lim, n_len, n_psz, n_cap};

    // never-written entries read as their reset values
    assign w_hit     = r_idx_ok && r_valid[r_addr];
    assign w_sel_psz = w_hit ? w_e_psz : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= t_cmd'(i_command);
            r_idx_ok <= (7'(i_buffer_index) < 7'(BUFFER_COUNT));
            r_addr   <= AW'(i_buffer_index);
            r_pages  <= i_page_count;
            r_base   <= i_base_word_addr;
            r_size   <= i_size_words;
            r_total  <= i_total_pages;
            r_psz_in <= i_page_words;
            r_bptr   <= i_byte_pointer;
            r_fmt    <= i_format_code;
        end
        if (i_ctl.step) begin
            if (w_hit) begin
                r_wr   <= w_e_wr;
                r_rd   <= w_e_rd;
                r_push <= w_e_push;
                r_pop  <= w_e_pop;
                r_tile <= w_e_tile;
                r_tsz  <= w_e_tsz;
                r_lim  <= w_e_lim;
                r_len  <= w_e_len;
                r_psz  <= w_e_psz;
                r_cap  <= w_e_cap;
            end else begin
                r_wr   <= '0;
                r_rd   <= '0;
                r_push <= '0;
                r_pop  <= '0;
                r_tile <= '0;
                r_tsz  <= TILE_WORDS_RESET;
                r_lim  <= '0;
                r_len  <= '0;
                r_psz  <= '0;
                r_cap  <= '0;
            end
            r_prod <= PRD_W'(r_pages) * PRD_W'(w_sel_psz);
        end
        if (i_ctl.commit) begin
            if (r_idx_ok) begin
                r_out_wr     <= {w_out_wptr(n_wr), 4'b0000};
                r_out_rd     <= {w_out_wptr(n_rd), 4'b0000};
                r_out_tile   <= n_tile;
                r_out_tbytes <= {n_tsz, 4'b0000};
                r_out_space  <= (w_free >= CNT_W'(r_pages));
                r_out_data   <= (w_used >= CNT_W'(r_pages));
            end else begin
                r_out_wr     <= '0;
                r_out_rd     <= '0;
                r_out_tile   <= '0;
                r_out_tbytes <= '0;
                r_out_space  <= 1'b0;
                r_out_data   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_wen) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    // pointer step: add, wrap once at the limit, keep LW bits
    assign w_adv_from = (r_cmd == CMD_PUSH) ? r_wr : r_rd;
    assign w_sum      = SUM_W'(w_adv_from) + SUM_W'(r_prod);
    assign w_wrapped  = (w_sum >= SUM_W'(r_lim)) ? (w_sum - SUM_W'(r_len)) : w_sum;
    assign w_adv      = PB'(w_wrapped[LW-1:0]);

    assign w_base_w = W'(r_base);
    assign w_len_w  = W'(r_size);

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_push = r_push;
        n_pop  = r_pop;
        n_tile = r_tile;
        n_tsz  = r_tsz;
        n_lim  = r_lim;
        n_len  = r_len;
        n_psz  = r_psz;
        n_cap  = r_cap;
        unique case (r_cmd)
            CMD_SETUP: begin
                n_len  = w_len_w;
                n_lim  = LW'(w_base_w) + LW'(w_len_w);
                n_psz  = W'(r_psz_in);
                n_cap  = r_total;
                n_wr   = PB'(w_base_w);
                n_rd   = PB'(w_base_w);
                n_push = '0;
                n_pop  = '0;
                n_tile = '0;
            end
            CMD_SET_FORMAT: begin
                n_tsz = tile_words(r_fmt);
            end
            CMD_PUSH: begin
                n_push = r_push + CNT_W'(r_pages);
                n_wr   = w_adv;
                n_tile = '0;
            end
            CMD_POP: begin
                n_pop = r_pop + CNT_W'(r_pages);
                n_rd  = w_adv;
            end
            CMD_SET_WR_PTR: begin
                n_wr = PB'(r_bptr[BPTR_W-1:4]);
            end
            CMD_SET_RD_PTR: begin
                n_rd = PB'(r_bptr[BPTR_W-1:4]);
            end
            CMD_INCR_TILE: begin
                n_tile = r_tile + r_pages;
            end
            default: begin
            end
        endcase
    end

    assign w_used = n_push - n_pop;
    assign w_free = CNT_W'(n_cap) - w_used;

    assign o_write_byte_ptr   = r_out_wr;
    assign o_read_byte_ptr    = r_out_rd;
    assign o_tile_write_index = r_out_tile;
    assign o_tile_bytes       = r_out_tbytes;
    assign o_space_ok         = r_out_space;
    assign o_data_ok          = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/paged_circular_buffer_manager_top.sv =====
// top level of the paged circular buffer manager: stream ports, controller and datapath
//
// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser: command, tdata: command operands
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: pointers, tile info, status flags
//
// every command runs through a state ram read, a multiply of pages by page size,
// then pointer wrap, counter update, ram write-back and result load.
// a new beat is taken in the cycle after write-back.
// reset clears the per-buffer valid bits at once; no clearing pass is needed.
// a result waiting on m_axis does not block the next beat, only its write-back.
`timescale 1ns / 1ps
`default_nettype none

module paged_circular_buffer_manager_top
    import pcbm_pkg::*;
#(
    parameter int BUFFER_COUNT   = 32,
    parameter int WORD_ADDR_BITS = 17
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // buffer_index[4:0], page_count[20:5], base_word_addr[37:21], size_words[54:38],
    // total_pages[70:55], page_words[87:71], byte_pointer[108:88], format_code[111:109]
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // command[3:0]
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // write_byte_ptr[20:0], read_byte_ptr[41:21], tile_write_index[57:42],
    // tile_bytes[70:58], space_ok[71], data_ok[72], zero[79:73]
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_dp_ctl               w_ctl;
    logic [BPTR_W-1:0]     w_wr_ptr;
    logic [BPTR_W-1:0]     w_rd_ptr;
    logic [TILE_IDX_W-1:0] w_tile;
    logic [TBYTES_W-1:0]   w_tbytes;
    logic                  w_space_ok;
    logic                  w_data_ok;

    pcbm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_ctl     (w_ctl)
    );

    pcbm_dp #(
        .BUFFER_COUNT   (BUFFER_COUNT),
        .WORD_ADDR_BITS (WORD_ADDR_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_command          (i_s_axis_tuser[3:0]),
        .i_buffer_index     (i_s_axis_tdata[4:0]),
        .i_page_count       (i_s_axis_tdata[20:5]),
        .i_base_word_addr   (i_s_axis_tdata[37:21]),
        .i_size_words       (i_s_axis_tdata[54:38]),
        .i_total_pages      (i_s_axis_tdata[70:55]),
        .i_page_words       (i_s_axis_tdata[87:71]),
        .i_byte_pointer     (i_s_axis_tdata[108:88]),
        .i_format_code      (i_s_axis_tdata[111:109]),
        .o_write_byte_ptr   (w_wr_ptr),
        .o_read_byte_ptr    (w_rd_ptr),
        .o_tile_write_index (w_tile),
        .o_tile_bytes       (w_tbytes),
        .o_space_ok         (w_space_ok),
        .o_data_ok          (w_data_ok)
    );

    assign o_m_axis_tdata = {7'b0000000, w_data_ok, w_space_ok, w_tbytes, w_tile,
                             w_rd_ptr, w_wr_ptr};

endmodule

`default_nettype wire

// ===== dv/paged_circular_buffer_manager_top_tb.sv =====
// testbench of the paged circular buffer manager: directed and random command beats checked against a predictor
`timescale 1ns / 1ps

module paged_circular_buffer_manager_top_tb;
    import pcbm_pkg::*;

    localparam int BUFFER_COUNT   = 32;
    localparam int WORD_ADDR_BITS = 17;
    localparam int PTR_W          = WORD_ADDR_BITS + 1;
    localparam int IDLE_PCT       = 23;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_BEATS   = 1200;
    localparam int STEADY_BEATS   = 300;
    localparam int POOL_SIZE      = 4;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [IDX_IN_W-1:0]  idx;
        logic [PAGE_W-1:0]    pages;
        logic [ADDR_IN_W-1:0] base;
        logic [ADDR_IN_W-1:0] len_words;
        logic [TOTAL_W-1:0]   total;
        logic [ADDR_IN_W-1:0] page_words;
        logic [BPTR_W-1:0]    byte_ptr;
        logic [FMT_W-1:0]     fmt;
    } pcb_cmd_t;

    typedef struct {
        logic [BPTR_W-1:0]     wr_bytes;
        logic [BPTR_W-1:0]     rd_bytes;
        logic [TILE_IDX_W-1:0] tile_idx;
        logic [TBYTES_W-1:0]   tile_bytes;
        logic                  space_ok;
        logic                  data_ok;
    } pcb_status_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    logic [S_TUSER_W-1:0] i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    // predicted per-buffer state
    logic [PTR_W-1:0]          m_wr         [BUFFER_COUNT];
    logic [PTR_W-1:0]          m_rd         [BUFFER_COUNT];
    logic [CNT_W-1:0]          m_pushed     [BUFFER_COUNT];
    logic [CNT_W-1:0]          m_popped     [BUFFER_COUNT];
    logic [TILE_IDX_W-1:0]     m_tile_idx   [BUFFER_COUNT];
    logic [TSZ_W-1:0]          m_tile_words [BUFFER_COUNT];
    logic [PTR_W-1:0]          m_limit      [BUFFER_COUNT];
    logic [ADDR_IN_W-1:0]      m_length     [BUFFER_COUNT];
    logic [ADDR_IN_W-1:0]      m_page_words [BUFFER_COUNT];
    logic [TOTAL_W-1:0]        m_capacity   [BUFFER_COUNT];

    pcb_status_t expected_status[$];
    int          mismatches;
    int          stall_cycles;
    bit          calm;

    paged_circular_buffer_manager_top #(
        .BUFFER_COUNT  (BUFFER_COUNT),
        .WORD_ADDR_BITS(WORD_ADDR_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void reset_buffers();
        for (int b = 0; b < BUFFER_COUNT; b++) begin
            m_wr[b]         = '0;
            m_rd[b]         = '0;
            m_pushed[b]     = '0;
            m_popped[b]     = '0;
            m_tile_idx[b]   = '0;
            m_tile_words[b] = 9'd256;
            m_limit[b]      = '0;
            m_length[b]     = '0;
            m_page_words[b] = '0;
            m_capacity[b]   = '0;
        end
    endfunction

    function automatic logic [TSZ_W-1:0] format_tile_words(input logic [FMT_W-1:0] fmt);
        case (fmt)
            FMT_HALF:    return 9'd128;
            FMT_FLOAT32: return 9'd256;
            FMT_BFP4:    return 9'd36;
            FMT_BFP2:    return 9'd20;
            default:     return 9'd68;
        endcase
    endfunction

    // one wrap at most: the sum is compared at full width before the mask
    function automatic logic [PTR_W-1:0] advance_ptr(input logic [PTR_W-1:0] ptr, input int b,
                                                     input logic [PAGE_W-1:0] pages);
        logic [63:0] sum;
        sum = 64'(ptr) + 64'(pages) * 64'(m_page_words[b]);
        if (sum >= 64'(m_limit[b]))
            sum = sum - 64'(m_length[b]);
        return sum[PTR_W-1:0];
    endfunction

    function automatic pcb_status_t apply_command(input pcb_cmd_t c);
        pcb_status_t s;
        int          b;
        logic [31:0] used;
        logic [31:0] free_pages;
        b = c.idx;
        case (c.cmd)
            CMD_SETUP: begin
                m_length[b]     = c.len_words;
                m_limit[b]      = PTR_W'(c.base) + PTR_W'(c.len_words);
                m_page_words[b] = c.page_words;
                m_capacity[b]   = c.total;
                m_wr[b]         = PTR_W'(c.base);
                m_rd[b]         = PTR_W'(c.base);
                m_pushed[b]     = '0;
                m_popped[b]     = '0;
                m_tile_idx[b]   = '0;
            end
            CMD_SET_FORMAT: m_tile_words[b] = format_tile_words(c.fmt);
            CMD_PUSH: begin
                m_pushed[b]   = m_pushed[b] + 32'(c.pages);
                m_wr[b]       = advance_ptr(m_wr[b], b, c.pages);
                m_tile_idx[b] = '0;
            end
            CMD_POP: begin
                m_popped[b] = m_popped[b] + 32'(c.pages);
                m_rd[b]     = advance_ptr(m_rd[b], b, c.pages);
            end
            CMD_SET_WR_PTR: m_wr[b] = PTR_W'(c.byte_ptr >> 4);
            CMD_SET_RD_PTR: m_rd[b] = PTR_W'(c.byte_ptr >> 4);
            CMD_INCR_TILE:  m_tile_idx[b] = m_tile_idx[b] + c.pages;
            default: ;
        endcase
        used         = m_pushed[b] - m_popped[b];
        free_pages   = 32'(m_capacity[b]) - used;
        s.wr_bytes   = BPTR_W'({m_wr[b], 4'b0000});
        s.rd_bytes   = BPTR_W'({m_rd[b], 4'b0000});
        s.tile_idx   = m_tile_idx[b];
        s.tile_bytes = TBYTES_W'({m_tile_words[b], 4'b0000});
        s.space_ok   = free_pages >= 32'(c.pages);
        s.data_ok    = used >= 32'(c.pages);
        return s;
    endfunction

    function automatic pcb_cmd_t random_cmd();
        pcb_cmd_t c;
        c.cmd        = CMD_W'($urandom);
        c.idx        = IDX_IN_W'($urandom);
        c.pages      = PAGE_W'($urandom);
        c.base       = ADDR_IN_W'($urandom);
        c.len_words  = ADDR_IN_W'($urandom);
        c.total      = TOTAL_W'($urandom);
        c.page_words = ADDR_IN_W'($urandom);
        c.byte_ptr   = BPTR_W'($urandom);
        c.fmt        = FMT_W'($urandom);
        return c;
    endfunction

    // fields the command does not use carry random noise
    function automatic pcb_cmd_t cmd_beat(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_IN_W-1:0] idx,
                                          input logic [PAGE_W-1:0] pages);
        pcb_cmd_t c;
        c       = random_cmd();
        c.cmd   = cmd;
        c.idx   = idx;
        c.pages = pages;
        return c;
    endfunction

    function automatic pcb_cmd_t setup_beat(input logic [IDX_IN_W-1:0] idx,
                                            input logic [ADDR_IN_W-1:0] base,
                                            input logic [ADDR_IN_W-1:0] len_words,
                                            input logic [TOTAL_W-1:0] total,
                                            input logic [ADDR_IN_W-1:0] page_words);
        pcb_cmd_t c;
        c            = cmd_beat(CMD_SETUP, idx, PAGE_W'($urandom));
        c.base       = base;
        c.len_words  = len_words;
        c.total      = total;
        c.page_words = page_words;
        return c;
    endfunction

    // small buffer whose pointers wrap after a few pushes
    function automatic pcb_cmd_t small_setup(input logic [IDX_IN_W-1:0] idx);
        int pw;
        int np;
        int len;
        pw  = $urandom_range(64, 1);
        np  = $urandom_range(16, 1);
        len = pw * np;
        return setup_beat(idx, ADDR_IN_W'($urandom_range(131071 - len, 0)), ADDR_IN_W'(len),
                          TOTAL_W'(np), ADDR_IN_W'(pw));
    endfunction

    task automatic send_cmd(input pcb_cmd_t c);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c.cmd;
        i_s_axis_tdata  <= {c.fmt, c.byte_ptr, c.page_words, c.total, c.len_words, c.base,
                            c.pages, c.idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_status.push_back(apply_command(c));
    endtask

    task automatic test_reset_state();
        send_cmd(cmd_beat(CMD_WAIT_Q, 5'd0, 16'd0));
        send_cmd(cmd_beat(CMD_RESERVE_Q, 5'd31, 16'hFFFF));
    endtask

    task automatic test_setup_extremes();
        send_cmd(setup_beat(5'd0, 17'd0, 17'h1FFFF, 16'hFFFF, 17'h1FFFF));
        send_cmd(setup_beat(5'd31, 17'h1FFFF, 17'h1FFFF, 16'd0, 17'd1));
        // huge advance, one subtraction and then the mask
        send_cmd(cmd_beat(CMD_PUSH, 5'd0, 16'hFFFF));
    endtask

    task automatic test_formats();
        pcb_cmd_t c;
        for (int f = 0; f < (1 << FMT_W); f++) begin
            c     = cmd_beat(CMD_SET_FORMAT, 5'd7, PAGE_W'($urandom));
            c.fmt = FMT_W'(f);
            send_cmd(c);
        end
    endtask

    task automatic test_wrap_and_flags();
        send_cmd(setup_beat(5'd3, 17'd100, 17'd40, 16'd4, 17'd10));
        send_cmd(cmd_beat(CMD_PUSH, 5'd3, 16'd3));
        send_cmd(cmd_beat(CMD_PUSH, 5'd3, 16'd2));
        send_cmd(cmd_beat(CMD_RESERVE_Q, 5'd3, 16'd0));
        send_cmd(cmd_beat(CMD_POP, 5'd3, 16'd4));
        // popped more than pushed: used count goes negative
        send_cmd(cmd_beat(CMD_POP, 5'd3, 16'd3));
    endtask

    task automatic test_pointers_and_tiles();
        pcb_cmd_t c;
        c          = cmd_beat(CMD_SET_WR_PTR, 5'd3, 16'd1);
        c.byte_ptr = 21'h1FFFFF;
        send_cmd(c);
        c          = cmd_beat(CMD_SET_RD_PTR, 5'd3, 16'd0);
        c.byte_ptr = 21'd0;
        send_cmd(c);
        send_cmd(cmd_beat(CMD_INCR_TILE, 5'd3, 16'hFFFF));
        send_cmd(cmd_beat(CMD_INCR_TILE, 5'd3, 16'd3));
        send_cmd(cmd_beat(CMD_UNUSED_LO, 5'd3, 16'd0));
        send_cmd(cmd_beat(CMD_PUSH, 5'd3, 16'd0));
        send_cmd(cmd_beat(CMD_UNUSED_HI, 5'd3, 16'd1));
    endtask

    task automatic test_random_traffic(input int n_beats);
        logic [IDX_IN_W-1:0] pool [POOL_SIZE];
        logic [IDX_IN_W-1:0] idx;
        pcb_cmd_t            c;
        int                  r;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool[k] = IDX_IN_W'($urandom);
            send_cmd(small_setup(pool[k]));
        end
        for (int n = 0; n < n_beats; n++) begin
            r   = $urandom_range(99);
            idx = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)]
                                            : IDX_IN_W'($urandom);
            if (r < 10)
                c = random_cmd();
            else if (r < 15)
                c = small_setup(idx);
            else if (r < 45)
                c = cmd_beat(CMD_PUSH, idx, PAGE_W'($urandom_range(3)));
            else if (r < 73)
                c = cmd_beat(CMD_POP, idx, PAGE_W'($urandom_range(3)));
            else if (r < 81)
                c = cmd_beat(CMD_RESERVE_Q, idx, PAGE_W'($urandom_range(16)));
            else if (r < 89)
                c = cmd_beat(CMD_WAIT_Q, idx, PAGE_W'($urandom_range(16)));
            else if (r < 93)
                c = cmd_beat(CMD_INCR_TILE, idx, PAGE_W'($urandom));
            else if (r < 96)
                c = cmd_beat(CMD_SET_FORMAT, idx, PAGE_W'($urandom));
            else if (r < 98)
                c = cmd_beat($urandom_range(1) ? CMD_SET_WR_PTR : CMD_SET_RD_PTR, idx,
                             PAGE_W'($urandom));
            else
                c = cmd_beat(CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), idx,
                             PAGE_W'($urandom));
            send_cmd(c);
        end
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        test_random_traffic(STEADY_BEATS);
        calm = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : status_check
        pcb_status_t got;
        pcb_status_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.wr_bytes   = o_m_axis_tdata[20:0];
            got.rd_bytes   = o_m_axis_tdata[41:21];
            got.tile_idx   = o_m_axis_tdata[57:42];
            got.tile_bytes = o_m_axis_tdata[70:58];
            got.space_ok   = o_m_axis_tdata[71];
            got.data_ok    = o_m_axis_tdata[72];
            if (expected_status.size() == 0) begin
                $display("%0t unexpected result beat: expected none, got %0h", $time,
                         o_m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                check_field("write_byte_ptr", 32'(want.wr_bytes), 32'(got.wr_bytes));
                check_field("read_byte_ptr", 32'(want.rd_bytes), 32'(got.rd_bytes));
                check_field("tile_write_index", 32'(want.tile_idx), 32'(got.tile_idx));
                check_field("tile_bytes", 32'(want.tile_bytes), 32'(got.tile_bytes));
                check_field("space_ok", 32'(want.space_ok), 32'(got.space_ok));
                check_field("data_ok", 32'(want.data_ok), 32'(got.data_ok));
            end
        end
    end

    // result side stalls at random except during the steady stretch
    always @(posedge i_clk)
        i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        calm            = 1'b0;
        mismatches      = 0;
        stall_cycles    = 0;
        reset_buffers();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_setup_extremes();
        test_formats();
        test_wrap_and_flags();
        test_pointers_and_tiles();
        test_random_traffic(RANDOM_BEATS);
        test_back_to_back();

        i_s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
